// ===== hw/rtl/fat12ca_pkg.sv =====
// Shared constants, codes and control types of the FAT12 cluster chain allocator.
package fat12ca_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int CLUSTER_BYTES = 512;

  localparam int IDX_W    = $clog2(TABLE_ENTRIES);
  localparam int CB_SHIFT = $clog2(CLUSTER_BYTES);
  localparam int CL_W     = 12;
  localparam int VAL_W    = 12;
  localparam int LEN_W    = 24;
  localparam int KIND_W   = 2;
  localparam int NEED_W   = LEN_W + 1 - CB_SHIFT;

  localparam logic [VAL_W-1:0] END_MARK      = 12'hFFF;
  localparam logic [CL_W-1:0]  HIGHEST_RESET = 12'd2838;
  localparam logic [IDX_W-1:0] FIRST_DATA    = IDX_W'(2);

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_ALLOC = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_DONE,
    ST_COUNT,
    ST_LINK,
    ST_FINISH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_cluster;
    logic capture_read;
    logic op_write;
    logic scan_start;
    logic scan_step;
    logic link;
    logic set_full;
    logic mark_end;
    logic clear;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  need_zero;
    logic  range_empty;
    logic  scan_done;
    logic  enough;
    logic  out_free;
    logic  clear_last;
  } status_t;

endpackage

// ===== hw/rtl/fat12ca_ctrl.sv =====
// Sequencer of the allocator: clearing pass, item dispatch, two-pass allocation scan.
module fat12ca_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fat12ca_pkg::status_t sts,
  output fat12ca_pkg::cmd_t    cmd
);
  import fat12ca_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.kind)
          KIND_READ: begin
            cmd.rd_cluster = 1'b1;
            state_nxt      = ST_RD_DONE;
          end
          KIND_WRITE: begin
            cmd.op_write = 1'b1;
            state_nxt    = ST_RESP;
          end
          KIND_ALLOC: begin
            if (sts.need_zero) begin
              state_nxt = ST_RESP;
            end else if (sts.range_empty) begin
              cmd.set_full = 1'b1;
              state_nxt    = ST_RESP;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_COUNT;
            end
          end
          default: begin
            state_nxt = ST_RESP;
          end
        endcase
      end
      ST_RD_DONE: begin
        cmd.capture_read = 1'b1;
        state_nxt        = ST_RESP;
      end
      ST_COUNT: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          if (sts.enough) begin
            // rewind the scan for the linking pass
            cmd.scan_start = 1'b1;
            state_nxt      = ST_LINK;
          end else begin
            cmd.set_full = 1'b1;
            state_nxt    = ST_RESP;
          end
        end
      end
      ST_LINK: begin
        cmd.scan_step = 1'b1;
        cmd.link      = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.mark_end = 1'b1;
        state_nxt    = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fat12ca_dpath.sv =====
// Datapath of the allocator: table memory, scan counters, result and output registers.
module fat12ca_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  fat12ca_pkg::cmd_t                    cmd,
  output fat12ca_pkg::status_t                 sts,
  input  logic                                 cfg_wr_en,
  input  logic [fat12ca_pkg::CL_W-1:0]         cfg_wr_data,
  input  logic [fat12ca_pkg::KIND_W-1:0]       in_kind,
  input  logic [fat12ca_pkg::CL_W-1:0]         in_cluster,
  input  logic [fat12ca_pkg::VAL_W-1:0]        in_value,
  input  logic [fat12ca_pkg::LEN_W-1:0]        in_byte_length,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fat12ca_pkg::VAL_W-1:0]        out_read_value,
  output logic [fat12ca_pkg::CL_W-1:0]         out_first_cluster,
  output logic                                 out_status
);
  import fat12ca_pkg::*;

  logic [VAL_W-1:0] mem [TABLE_ENTRIES];
  logic [VAL_W-1:0] dout_r;

  logic [CL_W-1:0]   highest_r;
  kind_t             kind_r;
  logic [CL_W-1:0]   cluster_r;
  logic [VAL_W-1:0]  value_r;
  logic [NEED_W-1:0] need_r;

  logic [IDX_W-1:0]  scan_addr_r;
  logic [IDX_W-1:0]  chk_addr_r;
  logic              chk_valid_r;
  logic [NEED_W-1:0] found_r;
  logic [IDX_W-1:0]  prev_r;
  logic              have_prev_r;
  logic [IDX_W-1:0]  first_r;

  logic [VAL_W-1:0] res_read_r;
  logic [CL_W-1:0]  res_first_r;
  logic             res_full_r;

  logic             out_valid_r;
  logic [VAL_W-1:0] out_read_r;
  logic [CL_W-1:0]  out_first_r;
  logic             out_full_r;

  logic [LEN_W:0]    len_sum;
  logic [NEED_W-1:0] need_nxt;
  logic [IDX_W-1:0]  lim;
  logic              in_range;
  logic              hit;
  logic [NEED_W-1:0] found_nxt;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;

  assign len_sum  = {1'b0, in_byte_length} + (LEN_W+1)'(CLUSTER_BYTES - 1);
  assign need_nxt = len_sum[LEN_W:CB_SHIFT];

  // clamp the scan to the last table entry
  assign lim = (highest_r > CL_W'(TABLE_ENTRIES - 1)) ? IDX_W'(TABLE_ENTRIES - 1)
                                                       : highest_r[IDX_W-1:0];
  assign in_range  = ({1'b0, cluster_r} < (CL_W+1)'(TABLE_ENTRIES));
  assign hit       = chk_valid_r && (dout_r == '0);
  assign found_nxt = found_r + NEED_W'(hit);

  assign rd_en   = cmd.rd_cluster | cmd.scan_step;
  assign rd_addr = cmd.rd_cluster ? cluster_r[IDX_W-1:0] : scan_addr_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = scan_addr_r;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we = 1'b1;
    end else if (cmd.op_write) begin
      mem_we    = in_range;
      mem_waddr = cluster_r[IDX_W-1:0];
      mem_wdata = value_r;
    end else if (cmd.mark_end) begin
      mem_we    = 1'b1;
      mem_waddr = prev_r;
      mem_wdata = END_MARK;
    end else if (cmd.link) begin
      // point the previous free cluster at this one
      mem_we    = hit && have_prev_r;
      mem_waddr = prev_r;
      mem_wdata = VAL_W'(chk_addr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      dout_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r <= HIGHEST_RESET;
    end else if (cfg_wr_en) begin
      highest_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= kind_t'(in_kind);
      cluster_r <= in_cluster;
      value_r   <= in_value;
      need_r    <= need_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r <= '0;
      chk_valid_r <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_addr_r <= FIRST_DATA;
      chk_valid_r <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
      chk_valid_r <= 1'b1;
    end else if (cmd.clear) begin
      scan_addr_r <= scan_addr_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      found_r     <= '0;
      have_prev_r <= 1'b0;
    end else if (cmd.scan_step) begin
      chk_addr_r <= scan_addr_r;
      if (hit) begin
        found_r <= found_nxt;
        if (cmd.link) begin
          prev_r      <= chk_addr_r;
          have_prev_r <= 1'b1;
          if (!have_prev_r) begin
            first_r <= chk_addr_r;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_read_r  <= '0;
      res_first_r <= '0;
      res_full_r  <= 1'b0;
    end else begin
      if (cmd.capture_read) begin
        res_read_r <= in_range ? dout_r : '0;
      end
      if (cmd.set_full) begin
        res_full_r <= 1'b1;
      end
      if (cmd.mark_end) begin
        res_first_r <= CL_W'(first_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_r  <= res_read_r;
      out_first_r <= res_first_r;
      out_full_r  <= res_full_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_r;
  assign out_first_cluster = out_first_r;
  assign out_status        = out_full_r;

  assign sts.kind        = kind_r;
  assign sts.need_zero   = (need_r == '0);
  assign sts.range_empty = (highest_r < CL_W'(FIRST_DATA));
  assign sts.scan_done   = chk_valid_r && ((found_nxt == need_r) || (chk_addr_r == lim));
  assign sts.enough      = (found_nxt == need_r);
  assign sts.out_free    = !out_valid_r || !out_stall;
  assign sts.clear_last  = (scan_addr_r == IDX_W'(TABLE_ENTRIES - 1));

`ifndef SYNTHESIS
  a_link_behind_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.link && mem_we) |-> (prev_r < chk_addr_r))
    else $error("link write not below the entry under test");

  a_found_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> (found_r <= need_r))
    else $error("free count ran past the cluster need");

  a_end_has_chain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_end |-> have_prev_r)
    else $error("end mark written with no cluster taken");

  a_full_no_chain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (!out_full_r || (out_first_r == '0)))
    else $error("full result carries a first cluster");
`endif

endmodule

// ===== hw/rtl/fat12_cluster_chain_allocator.sv =====
// Top level of the FAT12 cluster chain allocator: sequencer and datapath joined.
//
// After reset the block clears all 4096 entries of its table in one pass, during which
// in_stall stays high (configuration writes are taken throughout). Then a read item passes
// ST_DISPATCH, ST_RD_DONE and ST_RESP, a write item ST_DISPATCH and ST_RESP, and one result
// is delivered for every item. An allocation walks the table through its single read port
// one entry per cycle, twice: once to count free clusters from cluster 2 up and once to link
// them. Each walk stops at the last needed free cluster or at min(highest_cluster, 4095).
// A new item is taken while the previous result still waits on out_stall.
module fat12_cluster_chain_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [fat12ca_pkg::CL_W-1:0]         cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [fat12ca_pkg::KIND_W-1:0]       in_kind,
  input  logic [fat12ca_pkg::CL_W-1:0]         in_cluster,
  input  logic [fat12ca_pkg::VAL_W-1:0]        in_value,
  input  logic [fat12ca_pkg::LEN_W-1:0]        in_byte_length,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [fat12ca_pkg::VAL_W-1:0]        out_read_value,
  output logic [fat12ca_pkg::CL_W-1:0]         out_first_cluster,
  output logic                                 out_status
);
  import fat12ca_pkg::*;

  cmd_t    cmd;
  status_t sts;

  fat12ca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fat12ca_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_kind           (in_kind),
    .in_cluster        (in_cluster),
    .in_value          (in_value),
    .in_byte_length    (in_byte_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_value    (out_read_value),
    .out_first_cluster (out_first_cluster),
    .out_status        (out_status)
  );

endmodule
